// ===== rtl/icr_pkg.sv =====
// Shared types, register offsets and identification tables for the interrupt controller registers.
`timescale 1ns / 1ps

package icr_pkg;

	// Operation codes carried by each request word
	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	localparam int unsigned NumSourcesMax = 32;
	localparam int unsigned DataW         = 32;
	localparam int unsigned AddrW         = 12;
	localparam int unsigned IndexW        = 6;

	// Word offsets (byte address bits 11:2)
	typedef logic [AddrW-3:0] word_addr_t;

	localparam word_addr_t WaIrqStatus = 10'h000;
	localparam word_addr_t WaFiqStatus = 10'h001;
	localparam word_addr_t WaRaw       = 10'h002;
	localparam word_addr_t WaSelect    = 10'h003;
	localparam word_addr_t WaEnable    = 10'h004;
	localparam word_addr_t WaEnClear   = 10'h005;
	localparam word_addr_t WaSoft      = 10'h006;
	localparam word_addr_t WaSoftClear = 10'h007;
	localparam word_addr_t WaProtect   = 10'h008;

	// Upper byte-address nibbles 11:4 of the identification blocks
	localparam logic [7:0] PeriphIdBlock = 8'hFE;
	localparam logic [7:0] CellIdBlock   = 8'hFF;

	localparam logic signed [IndexW-1:0] NoneIndex = 6'sh3F;

	// Peripheral identification bytes, one per word
	function automatic logic [7:0] periph_id_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h90;
			2'd1: b = 8'h11;
			2'd2: b = 8'h04;
			2'd3: b = 8'h00;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Cell identification bytes, one per word
	function automatic logic [7:0] cell_id_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h0D;
			2'd1: b = 8'hF0;
			2'd2: b = 8'h05;
			2'd3: b = 8'hB1;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/icr_if.sv =====
// Request and response channel interfaces of the interrupt controller registers.
`timescale 1ns / 1ps

interface icr_req_if
	import icr_pkg::*;
();
	logic                     valid;
	logic                     ready;
	op_t                      operation;
	logic [AddrW-1:0]         address;
	logic [DataW-1:0]         write_data;
	logic [DataW-1:0]         source_lines;
	logic signed [IndexW-1:0] last_index;

	modport source (output valid, operation, address, write_data, source_lines, last_index,
		input ready);
	modport sink (input valid, operation, address, write_data, source_lines, last_index,
		output ready);
endinterface

interface icr_rsp_if
	import icr_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [DataW-1:0]         read_data;
	logic                     irq_out;
	logic                     fiq_out;
	logic signed [IndexW-1:0] next_irq;

	modport source (output valid, read_data, irq_out, fiq_out, next_irq, input ready);
	modport sink (input valid, read_data, irq_out, fiq_out, next_irq, output ready);
endinterface

// ===== rtl/interrupt_controller_registers.sv =====
// Top level: register file, status logic and next-pending search of the interrupt controller.
`timescale 1ns / 1ps

// Usage
//   req: one word per operation (bus read, bus write, sample of the source lines,
//        or a query for the lowest IRQ-pending source above last_index).
//   rsp: one word per request, in order: read_data, irq_out and fiq_out after the
//        operation, and next_irq (-1 when nothing is found or for other operations).
// Timing
//   A request word lands in the input register, is worked in one pass of masks and a
//   32-bit priority encoder, and sits in the output register until taken. One word per
//   cycle is sustained while rsp.ready stays high; the state registers are written in
//   the cycle a word moves from the input register to the output register.
// Reset
//   arst_n clears raw lines, soft pending, enable, select and protection, and empties
//   both registers. No clearing pass is needed.
// Stall
//   With rsp.ready low the output register holds; one more word is taken into the
//   input register, then req.ready drops until the response is taken.
module interrupt_controller_registers
	import icr_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = NumSourcesMax
) (
	input  logic          clk,
	input  logic          arst_n,
	icr_req_if.sink       req,
	icr_rsp_if.source     rsp
);

	localparam logic [DataW-1:0] SrcMask = (NUM_SOURCES >= DataW) ? {DataW{1'b1}} :
		DataW'((64'd1 << NUM_SOURCES) - 64'd1);

	// Input register
	logic                     valid_s1;
	op_t                      op_s1;
	word_addr_t               waddr_s1;
	logic [DataW-1:0]         wdata_s1;
	logic [DataW-1:0]         lines_s1;
	logic signed [IndexW-1:0] last_s1;

	// Output register
	logic                     valid_s2;
	logic [DataW-1:0]         rdata_s2;
	logic                     irq_s2;
	logic                     fiq_s2;
	logic signed [IndexW-1:0] next_s2;

	// Controller state
	logic [DataW-1:0] raw_lines_q;
	logic [DataW-1:0] soft_q;
	logic [DataW-1:0] enable_q;
	logic [DataW-1:0] select_q;
	logic             protect_q;

	logic advance_s2;
	logic advance_s1;

	assign advance_s2 = !valid_s2 || rsp.ready;
	assign advance_s1 = valid_s1 && advance_s2;
	assign req.ready  = !valid_s1 || advance_s2;

	// Capture the request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1    <= req.operation;
			waddr_s1 <= req.address[AddrW-1:2];
			wdata_s1 <= req.write_data;
			lines_s1 <= req.source_lines;
			last_s1  <= req.last_index;
		end
	end

	// Current status
	logic [DataW-1:0] raw_cur, irq_cur, fiq_cur;

	assign raw_cur = (raw_lines_q | soft_q) & SrcMask;
	assign irq_cur = raw_cur & enable_q & ~select_q;
	assign fiq_cur = raw_cur & enable_q & select_q;

	// Bus read mux
	logic [DataW-1:0] rdata_c;

	always_comb begin
		rdata_c = '0;
		case (waddr_s1)
			WaIrqStatus: rdata_c = irq_cur;
			WaFiqStatus: rdata_c = fiq_cur;
			WaRaw:       rdata_c = raw_cur;
			WaSelect:    rdata_c = select_q;
			WaEnable:    rdata_c = enable_q;
			WaSoft:      rdata_c = soft_q;
			WaProtect:   rdata_c = {{(DataW-1){1'b0}}, protect_q};
			default: begin
				if (waddr_s1[AddrW-3:2] == PeriphIdBlock)
					rdata_c = {{(DataW-8){1'b0}}, periph_id_byte(waddr_s1[1:0])};
				else if (waddr_s1[AddrW-3:2] == CellIdBlock)
					rdata_c = {{(DataW-8){1'b0}}, cell_id_byte(waddr_s1[1:0])};
			end
		endcase
		if (op_s1 != OP_READ)
			rdata_c = '0;
	end

	// Next state of the registers
	logic [DataW-1:0] wmask_c;
	logic [DataW-1:0] raw_lines_d, soft_d, enable_d, select_d;
	logic             protect_d;

	assign wmask_c = wdata_s1 & SrcMask;

	always_comb begin
		raw_lines_d = raw_lines_q;
		soft_d      = soft_q;
		enable_d    = enable_q;
		select_d    = select_q;
		protect_d   = protect_q;
		case (op_s1)
			OP_WRITE: begin
				case (waddr_s1)
					WaSelect:    select_d  = wmask_c;
					WaEnable:    enable_d  = enable_q | wmask_c;
					WaEnClear:   enable_d  = enable_q & ~wmask_c;
					WaSoft:      soft_d    = soft_q | wmask_c;
					WaSoftClear: soft_d    = soft_q & ~wmask_c;
					WaProtect:   protect_d = wdata_s1[0];
					default: ;
				endcase
			end
			OP_SAMPLE: raw_lines_d = lines_s1 & SrcMask;
			default: ;
		endcase
	end

	// Status after the operation
	logic [DataW-1:0] raw_nxt, irq_nxt, fiq_nxt;

	assign raw_nxt = (raw_lines_d | soft_d) & SrcMask;
	assign irq_nxt = raw_nxt & enable_d & ~select_d;
	assign fiq_nxt = raw_nxt & enable_d & select_d;

	// Find the lowest IRQ-pending source above last_index
	logic [DataW-1:0]         above_c;
	logic [DataW-1:0]         cand_c;
	logic signed [IndexW-1:0] next_c;

	always_comb begin
		for (int i = 0; i < DataW; i++)
			above_c[i] = $signed({1'b0, IndexW'(i)}) > $signed({last_s1[IndexW-1], last_s1});
		cand_c = irq_cur & above_c;
		next_c = NoneIndex;
		for (int i = DataW - 1; i >= 0; i--)
			if (cand_c[i])
				next_c = IndexW'(i);
		if (op_s1 != OP_QUERY)
			next_c = NoneIndex;
	end

	// Update state as the word moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_lines_q <= '0;
			soft_q      <= '0;
			enable_q    <= '0;
			select_q    <= '0;
			protect_q   <= 1'b0;
		end else if (advance_s1) begin
			raw_lines_q <= raw_lines_d;
			soft_q      <= soft_d;
			enable_q    <= enable_d;
			select_q    <= select_d;
			protect_q   <= protect_d;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rdata_s2 <= rdata_c;
			irq_s2   <= |irq_nxt;
			fiq_s2   <= |fiq_nxt;
			next_s2  <= next_c;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = rdata_s2;
	assign rsp.irq_out   = irq_s2;
	assign rsp.fiq_out   = fiq_s2;
	assign rsp.next_irq  = next_s2;

	// Pending flags shown match the held state
	a_flags_match_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (irq_s2 == (|irq_cur)) && (fiq_s2 == (|fiq_cur)))
		else $error("pending flags disagree with register state");

	// Absent sources stay clear
	a_absent_sources_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((raw_lines_q | soft_q | enable_q | select_q) & ~SrcMask) == '0)
		else $error("bit set above the last source");

	// Request stalls only with both registers full and the output stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && !rsp.ready)
		else $error("request stalled without cause");

	// A found index is a query result, not a read
	a_found_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && next_c != NoneIndex |-> rdata_c == '0 && op_s1 == OP_QUERY)
		else $error("index found outside a query");

	// A found index points at a pending IRQ source
	a_found_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && next_c != NoneIndex |-> !next_c[IndexW-1] && irq_cur[next_c[IndexW-2:0]])
		else $error("found index is not pending");

endmodule

// ===== dv/interrupt_controller_registers_tb.sv =====
// Self-checking testbench of the interrupt controller registers: directed and random words.
`timescale 1ns / 1ps

module interrupt_controller_registers_tb
	import icr_pkg::*;
();

	localparam int unsigned NumSources = NumSourcesMax;
	localparam int          IdleLimit  = 1000;
	localparam int          RandomWords = 160;

	localparam logic [3:0][7:0] PeriphIdBytes = {8'h00, 8'h04, 8'h11, 8'h90};
	localparam logic [3:0][7:0] CellIdBytes   = {8'hB1, 8'h05, 8'hF0, 8'h0D};
	localparam word_addr_t      WaUnmapped    = WaProtect + 10'd1;

	typedef struct packed {
		op_t                      operation;
		logic [AddrW-1:0]         address;
		logic [DataW-1:0]         write_data;
		logic [DataW-1:0]         source_lines;
		logic signed [IndexW-1:0] last_index;
	} icr_word_t;

	typedef struct packed {
		logic [DataW-1:0]         read_data;
		logic                     irq_out;
		logic                     fiq_out;
		logic signed [IndexW-1:0] next_irq;
	} icr_result_t;

	// Predict the controller registers and check responses in order
	class irq_register_scoreboard;
		logic [DataW-1:0] raw_lines;
		logic [DataW-1:0] soft_pending;
		logic [DataW-1:0] enable_mask;
		logic [DataW-1:0] fiq_select;
		logic             protect_bit;
		icr_result_t      pending_results[$];
		int               mismatches;

		function new();
			raw_lines    = '0;
			soft_pending = '0;
			enable_mask  = '0;
			fiq_select   = '0;
			protect_bit  = 1'b0;
			mismatches   = 0;
		endfunction

		function logic [DataW-1:0] present_mask();
			return (NumSources >= DataW) ? '1 : ((DataW'(1) << NumSources) - DataW'(1));
		endfunction

		function logic [DataW-1:0] raw_status();
			return (raw_lines | soft_pending) & present_mask();
		endfunction

		function logic [DataW-1:0] irq_status();
			return raw_status() & enable_mask & ~fiq_select;
		endfunction

		function logic [DataW-1:0] fiq_status();
			return raw_status() & enable_mask & fiq_select;
		endfunction

		function logic [DataW-1:0] read_reg(logic [AddrW-1:0] addr);
			logic [DataW-1:0] value;
			value = '0;
			case (addr[AddrW-1:2])
				WaIrqStatus: value = irq_status();
				WaFiqStatus: value = fiq_status();
				WaRaw:       value = raw_status();
				WaSelect:    value = fiq_select;
				WaEnable:    value = enable_mask;
				WaSoft:      value = soft_pending;
				WaProtect:   value = {{(DataW-1){1'b0}}, protect_bit};
				default: begin
					// Identification words carry one byte each; clear registers read zero
					if (addr[AddrW-1:4] == PeriphIdBlock)
						value = {24'h0, PeriphIdBytes[addr[3:2]]};
					else if (addr[AddrW-1:4] == CellIdBlock)
						value = {24'h0, CellIdBytes[addr[3:2]]};
				end
			endcase
			return value;
		endfunction

		function void write_reg(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
			logic [DataW-1:0] bits;
			bits = data & present_mask();
			case (addr[AddrW-1:2])
				WaSelect:    fiq_select = bits;
				WaEnable:    enable_mask = enable_mask | bits;
				WaEnClear:   enable_mask = enable_mask & ~bits;
				WaSoft:      soft_pending = soft_pending | bits;
				WaSoftClear: soft_pending = soft_pending & ~bits;
				WaProtect:   protect_bit = data[0];
				default: ;
			endcase
		endfunction

		// Lowest IRQ-pending source strictly above the given index
		function logic signed [IndexW-1:0] lowest_irq_above(logic signed [IndexW-1:0] last);
			logic [DataW-1:0] pending;
			int               first;
			pending = irq_status();
			first = int'(last) + 1;
			if (first < 0)
				first = 0;
			for (int i = first; i < int'(NumSources) && i < DataW; i++) begin
				if (pending[i])
					return IndexW'(i);
			end
			return NoneIndex;
		endfunction

		function void note_request(icr_word_t w);
			icr_result_t res;
			res.read_data = '0;
			res.next_irq  = NoneIndex;
			case (w.operation)
				OP_READ:   res.read_data = read_reg(w.address);
				OP_WRITE:  write_reg(w.address, w.write_data);
				OP_SAMPLE: raw_lines = w.source_lines & present_mask();
				OP_QUERY:  res.next_irq = lowest_irq_above(w.last_index);
				default: ;
			endcase
			res.irq_out = |irq_status();
			res.fiq_out = |fiq_status();
			pending_results.push_back(res);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		function void compare_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] got);
			if (got !== exp)
				flag($sformatf("%s mismatch: expected %h, got %h", name, exp, got));
		endfunction

		function void check_response(icr_result_t got);
			icr_result_t exp;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected response word %h", got));
				return;
			end
			exp = pending_results.pop_front();
			compare_field("read_data", exp.read_data, got.read_data);
			compare_field("irq_out", DataW'(exp.irq_out), DataW'(got.irq_out));
			compare_field("fiq_out", DataW'(exp.fiq_out), DataW'(got.fiq_out));
			compare_field("next_irq", DataW'(exp.next_irq), DataW'(got.next_irq));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_gap_pct;
	int   recv_stall_pct;
	int   idle_cycles;

	irq_register_scoreboard sb;

	icr_req_if req_ch ();
	icr_rsp_if rsp_ch ();

	interrupt_controller_registers #(
		.NUM_SOURCES(NumSources)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [AddrW-1:0] byte_addr(word_addr_t wa);
		return {wa, 2'b00};
	endfunction

	function automatic icr_word_t make_word(op_t op, logic [AddrW-1:0] addr,
			logic [DataW-1:0] data, logic signed [IndexW-1:0] last);
		icr_word_t w;
		w.operation    = op;
		w.address      = addr;
		w.write_data   = data;
		w.source_lines = data;
		w.last_index   = last;
		return w;
	endfunction

	function automatic logic [DataW-1:0] random_bits();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return $urandom;
		else if (pick < 85)
			return $urandom & $urandom & $urandom;
		else if (pick < 93)
			return '1;
		return DataW'(1) << $urandom_range(DataW - 1);
	endfunction

	// Mostly mapped registers, some identification words, some anywhere
	function automatic icr_word_t random_word();
		icr_word_t   w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 30)
			w.operation = OP_READ;
		else if (pick < 62)
			w.operation = OP_WRITE;
		else if (pick < 77)
			w.operation = OP_SAMPLE;
		else
			w.operation = OP_QUERY;
		pick = $urandom_range(99);
		if (pick < 80)
			w.address = {word_addr_t'($urandom_range(WaProtect)), 2'($urandom)};
		else if (pick < 90)
			w.address = {($urandom_range(1) != 0) ? PeriphIdBlock : CellIdBlock, 4'($urandom)};
		else
			w.address = AddrW'($urandom);
		w.write_data   = random_bits();
		w.source_lines = random_bits();
		if ($urandom_range(3) != 0)
			w.last_index = IndexW'(int'($urandom_range(NumSources)) - 1);
		else
			w.last_index = IndexW'($urandom);
		return w;
	endfunction

	// Offer one word, idling at random, and hold it until the block takes it
	task automatic send_word(icr_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.operation    = w.operation;
		req_ch.address      = w.address;
		req_ch.write_data   = w.write_data;
		req_ch.source_lines = w.source_lines;
		req_ch.last_index   = w.last_index;
		req_ch.valid        = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(w);
	endtask

	// Stall the response side at random
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every response word taken
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response({rsp_ch.read_data, rsp_ch.irq_out, rsp_ch.fiq_out,
				rsp_ch.next_irq});
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		send_gap_pct = 16;
		recv_stall_pct = 49;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_READ;
		req_ch.address = '0;
		req_ch.write_data = '0;
		req_ch.source_lines = '0;
		req_ch.last_index = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Identification words, with ignored low address bits
		send_word(make_word(OP_READ, {PeriphIdBlock, 4'h0}, '0, '0));
		send_word(make_word(OP_READ, {PeriphIdBlock, 4'h7}, '0, '0));
		send_word(make_word(OP_READ, {CellIdBlock, 4'h0}, '0, '0));
		send_word(make_word(OP_READ, {CellIdBlock, 4'hF}, '0, '0));
		// Enable everything, raise all lines, route odd sources to FIQ
		send_word(make_word(OP_WRITE, byte_addr(WaEnable), '1, '0));
		send_word(make_word(OP_SAMPLE, '0, '1, '0));
		send_word(make_word(OP_WRITE, byte_addr(WaSelect), 32'hAAAA_AAAA, '0));
		send_word(make_word(OP_READ, byte_addr(WaFiqStatus), '0, '0));
		send_word(make_word(OP_READ, byte_addr(WaIrqStatus), '0, '0));
		send_word(make_word(OP_READ, byte_addr(WaRaw), '0, '0));
		// Queries: most negative index, minus one, top index, next to top
		send_word(make_word(OP_QUERY, '0, '0, -32));
		send_word(make_word(OP_QUERY, '0, '0, -1));
		send_word(make_word(OP_QUERY, '0, '0, 31));
		send_word(make_word(OP_QUERY, '0, '0, 30));
		// Clear half the enables; clear registers read back zero
		send_word(make_word(OP_WRITE, byte_addr(WaEnClear), 32'h0000_FFFF, '0));
		send_word(make_word(OP_READ, byte_addr(WaEnClear), '0, '0));
		// Software pending set and clear
		send_word(make_word(OP_WRITE, byte_addr(WaSoft), 32'h8000_0001, '0));
		send_word(make_word(OP_READ, byte_addr(WaSoft), '0, '0));
		send_word(make_word(OP_WRITE, byte_addr(WaSoftClear), 32'h8000_0000, '0));
		send_word(make_word(OP_READ, byte_addr(WaSoftClear), '0, '0));
		// Protection is stored but not enforced
		send_word(make_word(OP_WRITE, byte_addr(WaProtect), '1, '0));
		send_word(make_word(OP_READ, byte_addr(WaProtect), '0, '0));
		// A write to a read-only word is dropped; an unmapped word reads zero
		send_word(make_word(OP_WRITE, byte_addr(WaIrqStatus), '1, '0));
		send_word(make_word(OP_READ, byte_addr(WaUnmapped), '0, '0));
		send_word(make_word(OP_SAMPLE, '0, '0, '0));

		// Random words under three idling patterns
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct   = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
			recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 16 : 0;
			for (int n = 0; n < RandomWords; n++)
				send_word(random_word());
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		// Drain, then give stray responses a chance to show up
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
